FILE: src/hjbd_pkg.sv
// Shared types, codes and helpers for the headset jack and button detector.
// Depends on nothing; imported by every module of the block.
package hjbd_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_CNT_W  = 4;
    localparam int CFG_IVL_W  = 8;

    // Widest timer the design supports; timers are cut down from this
    localparam int TMR_MAX_W  = 20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_JACK_ABSENT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JACK_PRESENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INSERT_SETTLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_FIRST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_PRESS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_RELEASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_CNT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_IVL   = 3'd7;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] RST_JACK_ABSENT   = 10'd200;
    localparam logic [CFG_DATA_W-1:0] RST_JACK_PRESENT  = 10'd20;
    localparam logic [CFG_DATA_W-1:0] RST_INSERT_SETTLE = 10'd200;
    localparam logic [CFG_DATA_W-1:0] RST_BTN_FIRST     = 10'd50;
    localparam logic [CFG_DATA_W-1:0] RST_BTN_PRESS     = 10'd10;
    localparam logic [CFG_DATA_W-1:0] RST_BTN_RELEASE   = 10'd150;
    localparam logic [CFG_CNT_W-1:0]  RST_CONFIRM_CNT   = 4'd12;
    localparam logic [CFG_IVL_W-1:0]  RST_CONFIRM_IVL   = 8'd10;

    // Plug and button event codes
    localparam logic [1:0] PLUG_NONE     = 2'd0;
    localparam logic [1:0] PLUG_INSERTED = 2'd1;
    localparam logic [1:0] PLUG_REMOVED  = 2'd2;
    localparam logic [1:0] BTN_NONE      = 2'd0;
    localparam logic [1:0] BTN_PRESS     = 2'd1;
    localparam logic [1:0] BTN_RELEASE   = 2'd2;

    typedef enum logic [1:0] {
        JK_IDLE     = 2'd0,
        JK_DEBOUNCE = 2'd1,
        JK_SETTLE   = 2'd2
    } hjbd_jack_phase_t;

    typedef enum logic [1:0] {
        BT_IDLE     = 2'd0,
        BT_DEBOUNCE = 2'd1,
        BT_CONFIRM  = 2'd2
    } hjbd_btn_phase_t;

    // Which button debounce length applies next
    typedef enum logic [1:0] {
        CH_FIRST   = 2'd0,
        CH_PRESS   = 2'd1,
        CH_RELEASE = 2'd2
    } hjbd_choice_t;

    typedef struct packed {
        logic jack_level;
        logic button_level;
    } hjbd_in_t;

    typedef struct packed {
        logic       headset_present;
        logic       button_down;
        logic [1:0] plug_event;
        logic [1:0] button_event;
        logic       switch_enable;
    } hjbd_out_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] jack_debounce_absent_ms;
        logic [CFG_DATA_W-1:0] jack_debounce_present_ms;
        logic [CFG_DATA_W-1:0] insert_settle_ms;
        logic [CFG_DATA_W-1:0] button_debounce_first_ms;
        logic [CFG_DATA_W-1:0] button_debounce_after_press_ms;
        logic [CFG_DATA_W-1:0] button_debounce_after_release_ms;
        logic [CFG_CNT_W-1:0]  confirm_samples;
        logic [CFG_IVL_W-1:0]  confirm_interval_ms;
    } hjbd_cfg_t;

    // Jack path status seen by the button path for the current tick
    typedef struct packed {
        logic was_present;
        logic present;
        logic inserted;
        logic removed;
        logic arm_ignore;
    } hjbd_jack_t;

    // Timer load value: zero acts as one, long values clip to tmax
    function automatic logic [TMR_MAX_W-1:0] load_len(
        input logic [CFG_DATA_W-1:0] len,
        input logic [TMR_MAX_W-1:0]  tmax
    );
        logic [TMR_MAX_W-1:0] l;
        l = {{(TMR_MAX_W-CFG_DATA_W){1'b0}}, len};
        if (l == '0)
        begin
            l = {{(TMR_MAX_W-1){1'b0}}, 1'b1};
        end
        if (l > tmax)
        begin
            l = tmax;
        end
        return l;
    endfunction

endpackage

FILE: src/headset_jack_and_button_detector.sv
// Top level of the headset jack and button detector.
// Depends on hjbd_pkg, hjbd_jack and hjbd_button.
//
// Usage: send one request per 1 ms tick on the input channel (in_valid,
// in_stall, in_data) carrying the sampled jack pin (low = plug present) and
// button pin (high = held). Every request yields exactly one result on the
// output channel (out_valid, out_stall, out_data): presence, button state,
// plug and button events, and the popup switch enable drive.
// The request lands in an input register; once the result register is free,
// the jack and button logic update and load it. Throughput is one request
// per cycle while the receiver does not stall; the only state is a few
// flags and down-counters, updated in a single pass per request. When the
// receiver stalls, the result register holds its value and the input
// register still takes one more request, so in_stall rises only once both
// registers are full. Reset clears all state: no headset, long jack
// debounce, button idle, switch off, and loads the default register values.
// The user must write the registers through cfg_wr_en/cfg_index/cfg_wdata
// only while no request is in flight; the block does not enforce this.
module headset_jack_and_button_detector
    import hjbd_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  hjbd_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output hjbd_out_t             out_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    hjbd_cfg_t  cfg_reg;
    logic       s1_valid_reg;
    hjbd_in_t   s1_data_reg;
    logic       out_valid_reg;
    hjbd_out_t  out_data_reg, out_data_next;
    logic       step;
    hjbd_jack_t jack_status;

    // Pipeline handshake
    assign step      = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !step;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jack_debounce_absent_ms          <= RST_JACK_ABSENT;
            cfg_reg.jack_debounce_present_ms         <= RST_JACK_PRESENT;
            cfg_reg.insert_settle_ms                 <= RST_INSERT_SETTLE;
            cfg_reg.button_debounce_first_ms         <= RST_BTN_FIRST;
            cfg_reg.button_debounce_after_press_ms   <= RST_BTN_PRESS;
            cfg_reg.button_debounce_after_release_ms <= RST_BTN_RELEASE;
            cfg_reg.confirm_samples                  <= RST_CONFIRM_CNT;
            cfg_reg.confirm_interval_ms              <= RST_CONFIRM_IVL;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_JACK_ABSENT:   cfg_reg.jack_debounce_absent_ms          <= cfg_wdata;
                CFG_JACK_PRESENT:  cfg_reg.jack_debounce_present_ms         <= cfg_wdata;
                CFG_INSERT_SETTLE: cfg_reg.insert_settle_ms                 <= cfg_wdata;
                CFG_BTN_FIRST:     cfg_reg.button_debounce_first_ms         <= cfg_wdata;
                CFG_BTN_PRESS:     cfg_reg.button_debounce_after_press_ms   <= cfg_wdata;
                CFG_BTN_RELEASE:   cfg_reg.button_debounce_after_release_ms <= cfg_wdata;
                CFG_CONFIRM_CNT:   cfg_reg.confirm_samples     <= cfg_wdata[CFG_CNT_W-1:0];
                CFG_CONFIRM_IVL:   cfg_reg.confirm_interval_ms <= cfg_wdata[CFG_IVL_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Jack path
    hjbd_jack #(
        .TIMER_BITS (TIMER_BITS)
    ) u_jack (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .jack_level    (s1_data_reg.jack_level),
        .cfg           (cfg_reg),
        .status        (jack_status),
        .plug_event    (out_data_next.plug_event),
        .switch_enable (out_data_next.switch_enable)
    );

    assign out_data_next.headset_present = jack_status.present;

    // Button path
    hjbd_button #(
        .TIMER_BITS (TIMER_BITS)
    ) u_button (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .button_level (s1_data_reg.button_level),
        .jack         (jack_status),
        .cfg          (cfg_reg),
        .button_down  (out_data_next.button_down),
        .button_event (out_data_next.button_event)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_data_reg <= in_data;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Result consistency checks
    a_insert_present: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.plug_event == PLUG_INSERTED)
            |-> out_data_reg.headset_present)
        else $error("insertion reported without presence");

    a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.plug_event == PLUG_REMOVED)
            |-> (!out_data_reg.headset_present && !out_data_reg.button_down
                 && !out_data_reg.switch_enable))
        else $error("removal left presence, button or switch set");

    a_button_needs_headset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.button_down) |-> out_data_reg.headset_present)
        else $error("button reported down without a headset");

    a_press_sets_down: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.button_event == BTN_PRESS)
            |-> out_data_reg.button_down)
        else $error("press reported but button not down");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed request did not reach the result register");

endmodule

FILE: src/hjbd_jack.sv
// Jack sense path: debounce, popup switch settle and presence state.
// Depends on hjbd_pkg; instantiated by headset_jack_and_button_detector.
module hjbd_jack
    import hjbd_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       jack_level,
    input  hjbd_cfg_t  cfg,
    output hjbd_jack_t status,
    output logic [1:0] plug_event,
    output logic       switch_enable
);

    localparam logic [TMR_MAX_W-1:0] TMAX = TMR_MAX_W'((64'd1 << TIMER_BITS) - 64'd1);

    hjbd_jack_phase_t        phase_reg, phase_next;
    logic [TIMER_BITS-1:0]   timer_reg, timer_next;
    logic                    present_reg, present_next;
    logic                    long_reg, long_next;
    logic                    switch_reg, switch_next;
    logic                    last_reg;

    logic [TMR_MAX_W-1:0]    deb_len_w, settle_len_w;
    logic [TIMER_BITS-1:0]   t_dec;
    logic                    expired, disagree, in_settle;
    logic                    settle_done, start, deb_done;
    logic                    do_insert, do_remove, do_settle, settle_fail;

    // Loaded lengths
    assign deb_len_w    = load_len(long_reg ? cfg.jack_debounce_absent_ms
                                            : cfg.jack_debounce_present_ms, TMAX);
    assign settle_len_w = load_len(cfg.insert_settle_ms, TMAX);

    // Tick decode
    assign t_dec       = (timer_reg != '0) ? timer_reg - TIMER_BITS'(1) : '0;
    assign expired     = (t_dec == '0);
    assign disagree    = present_reg ? jack_level : !jack_level;
    assign in_settle   = (phase_reg == JK_SETTLE);
    assign settle_done = in_settle && expired;
    assign start       = !in_settle && disagree &&
                         ((phase_reg == JK_IDLE) || (jack_level != last_reg));
    assign deb_done    = !in_settle && !start && (phase_reg == JK_DEBOUNCE) && expired;
    assign do_insert   = settle_done && !jack_level;
    assign settle_fail = settle_done && jack_level;
    assign do_remove   = deb_done && jack_level && present_reg;
    assign do_settle   = deb_done && !jack_level && !present_reg;

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        present_next = present_reg;
        long_next    = long_reg;
        switch_next  = switch_reg;
        case (phase_reg)
            JK_SETTLE:
            begin
                timer_next = t_dec;
                if (expired)
                begin
                    phase_next = JK_IDLE;
                end
            end
            JK_DEBOUNCE:
            begin
                if (start)
                begin
                    timer_next = deb_len_w[TIMER_BITS-1:0];
                end
                else
                begin
                    timer_next = t_dec;
                    if (expired)
                    begin
                        phase_next = JK_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = JK_IDLE;
                if (start)
                begin
                    phase_next = JK_DEBOUNCE;
                    timer_next = deb_len_w[TIMER_BITS-1:0];
                end
            end
        endcase
        if (do_settle)
        begin
            phase_next  = JK_SETTLE;
            timer_next  = settle_len_w[TIMER_BITS-1:0];
            switch_next = 1'b1;
        end
        if (do_insert)
        begin
            present_next = 1'b1;
            long_next    = 1'b0;
        end
        if (settle_fail)
        begin
            switch_next = 1'b0;
        end
        if (do_remove)
        begin
            present_next = 1'b0;
            long_next    = 1'b1;
            switch_next  = 1'b0;
        end
    end

    // Outputs for this tick
    always_comb
    begin
        status.was_present = present_reg;
        status.present     = present_next;
        status.inserted    = do_insert;
        status.removed     = do_remove;
        status.arm_ignore  = start && present_reg;
        switch_enable      = switch_next;
        if (do_insert)
        begin
            plug_event = PLUG_INSERTED;
        end
        else if (do_remove)
        begin
            plug_event = PLUG_REMOVED;
        end
        else
        begin
            plug_event = PLUG_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= JK_IDLE;
            timer_reg   <= '0;
            present_reg <= 1'b0;
            long_reg    <= 1'b1;
            switch_reg  <= 1'b0;
            last_reg    <= 1'b1;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            present_reg <= present_next;
            long_reg    <= long_next;
            switch_reg  <= switch_next;
            last_reg    <= jack_level;
        end
    end

endmodule

FILE: src/hjbd_button.sv
// Button path: debounce, confirmation sampling and press/release decision.
// Depends on hjbd_pkg and the jack status from hjbd_jack.
module hjbd_button
    import hjbd_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       button_level,
    input  hjbd_jack_t jack,
    input  hjbd_cfg_t  cfg,
    output logic       button_down,
    output logic [1:0] button_event
);

    localparam logic [TMR_MAX_W-1:0] TMAX = TMR_MAX_W'((64'd1 << TIMER_BITS) - 64'd1);

    hjbd_btn_phase_t        phase_reg, phase_next;
    logic [TIMER_BITS-1:0]  timer_reg, timer_next;
    logic [CFG_CNT_W-1:0]   count_reg, count_next;
    logic                   seen_reg, seen_next;
    hjbd_choice_t           choice_reg, choice_next;
    logic                   pressed_reg, pressed_next;
    logic                   ignore_reg, ignore_next;

    logic [CFG_DATA_W-1:0]  deb_sel;
    logic [TMR_MAX_W-1:0]   deb_len_w, ivl_len_w;
    logic [TIMER_BITS-1:0]  t_dec;
    logic [CFG_CNT_W-1:0]   cnt_dec;
    logic                   run, ign_eff, expired, in_conf;
    logic                   conf_tick, conf_abort, conf_ok, conf_last;
    logic                   change, deb_tick, deb_direct;
    logic                   decide_en, do_press, do_release, rel_remove;

    // Debounce length by last decision
    always_comb
    begin
        case (choice_reg)
            CH_PRESS:   deb_sel = cfg.button_debounce_after_press_ms;
            CH_RELEASE: deb_sel = cfg.button_debounce_after_release_ms;
            default:    deb_sel = cfg.button_debounce_first_ms;
        endcase
    end

    assign deb_len_w = load_len(deb_sel, TMAX);
    assign ivl_len_w = load_len({{(CFG_DATA_W-CFG_IVL_W){1'b0}}, cfg.confirm_interval_ms},
                                TMAX);

    // Tick decode
    assign run        = jack.was_present && jack.present;
    assign ign_eff    = ignore_reg || jack.arm_ignore;
    assign t_dec      = (timer_reg != '0) ? timer_reg - TIMER_BITS'(1) : '0;
    assign expired    = (t_dec == '0);
    assign cnt_dec    = (count_reg != '0) ? count_reg - CFG_CNT_W'(1) : '0;
    assign in_conf    = (phase_reg == BT_CONFIRM);
    assign conf_tick  = run && in_conf && expired;
    assign conf_abort = conf_tick && (button_level != seen_reg);
    assign conf_ok    = conf_tick && (button_level == seen_reg);
    assign conf_last  = conf_ok && (cnt_dec == '0);
    assign change     = run && !in_conf && (button_level != seen_reg);
    assign deb_tick   = run && !in_conf && !change && (phase_reg == BT_DEBOUNCE) && expired;
    assign deb_direct = deb_tick && (cfg.confirm_samples == '0);

    // Decision: the decided level always equals the stored level
    assign decide_en  = conf_last || deb_direct;
    assign do_press   = decide_en && seen_reg && !ign_eff && !pressed_reg;
    assign do_release = decide_en && !seen_reg && !ign_eff && pressed_reg;
    assign rel_remove = jack.removed && pressed_reg;

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        count_next   = count_reg;
        seen_next    = seen_reg;
        choice_next  = choice_reg;
        pressed_next = pressed_reg;
        ignore_next  = ign_eff;
        if (run)
        begin
            case (phase_reg)
                BT_CONFIRM:
                begin
                    timer_next = t_dec;
                    if (conf_abort)
                    begin
                        phase_next = BT_IDLE;
                    end
                    if (conf_ok)
                    begin
                        count_next = cnt_dec;
                        if (!conf_last)
                        begin
                            timer_next = ivl_len_w[TIMER_BITS-1:0];
                        end
                    end
                end
                BT_DEBOUNCE:
                begin
                    if (change)
                    begin
                        timer_next = deb_len_w[TIMER_BITS-1:0];
                    end
                    else
                    begin
                        timer_next = t_dec;
                        if (deb_tick)
                        begin
                            count_next = cfg.confirm_samples;
                            if (!deb_direct)
                            begin
                                phase_next = BT_CONFIRM;
                                timer_next = ivl_len_w[TIMER_BITS-1:0];
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = BT_IDLE;
                    if (change)
                    begin
                        phase_next = BT_DEBOUNCE;
                        timer_next = deb_len_w[TIMER_BITS-1:0];
                    end
                end
            endcase
            if (change)
            begin
                seen_next = button_level;
            end
        end
        if (decide_en)
        begin
            phase_next  = BT_IDLE;
            choice_next = seen_reg ? CH_PRESS : CH_RELEASE;
            if (!seen_reg && ign_eff)
            begin
                ignore_next = 1'b0;
            end
        end
        if (do_press)
        begin
            pressed_next = 1'b1;
        end
        if (do_release)
        begin
            pressed_next = 1'b0;
        end
        if (jack.inserted)
        begin
            phase_next = BT_IDLE;
            seen_next  = 1'b0;
        end
        if (jack.removed)
        begin
            phase_next   = BT_IDLE;
            pressed_next = 1'b0;
        end
    end

    // Outputs for this tick
    always_comb
    begin
        button_down = pressed_next;
        if (do_press)
        begin
            button_event = BTN_PRESS;
        end
        else if (do_release || rel_remove)
        begin
            button_event = BTN_RELEASE;
        end
        else
        begin
            button_event = BTN_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= BT_IDLE;
            timer_reg   <= '0;
            count_reg   <= '0;
            seen_reg    <= 1'b0;
            choice_reg  <= CH_FIRST;
            pressed_reg <= 1'b0;
            ignore_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            count_reg   <= count_next;
            seen_reg    <= seen_next;
            choice_reg  <= choice_next;
            pressed_reg <= pressed_next;
            ignore_reg  <= ignore_next;
        end
    end

endmodule
